// ----- hdl/cbspl_pkg.sv -----
// ----------------------------------------------------------------------------
// cbspl_pkg - shared types and constants for the cubic B-spline evaluator
// Payload structs, codes, widths and the controller/datapath interface.
// ----------------------------------------------------------------------------
package cbspl_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int FRAC_BITS  = 16;

    localparam int NUM_TAPS   = 4;
    localparam int NUM_AXES   = 3;
    localparam int COORD_W    = 32;
    localparam int SEG_W      = 10;
    localparam int FRAC_IN_W  = 16;

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int IDX_W  = ((CNT_W > SEG_W) ? CNT_W : SEG_W) + 1;

    // weight numerators: |w| < 8 * 2^F
    localparam int WGT_W  = FRAC_BITS + 4;
    localparam int PROD_W = COORD_W + WGT_W;
    localparam int SUM_W  = PROD_W + 2;
    // sum after rounding offset and shift by F+1
    localparam int S1_W   = SUM_W - FRAC_BITS - 1;

    // position divide by three: offset dividend below 6 * 2^31 < 2^34
    localparam int U_W           = 34;
    localparam int DIV_STEP_BITS = 8;
    localparam int DIV_W         = 40;
    localparam int DIV_STEPS     = DIV_W / DIV_STEP_BITS;
    localparam int STEP_W        = 3;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_POS    = 2'd1,
        FUNC_TAN    = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_SEG_ERR = 2'd1,
        STATUS_FULL    = 2'd2
    } status_t;

    typedef struct packed {
        func_t                  func;
        logic signed [31:0]     point_x;
        logic signed [31:0]     point_y;
        logic signed [31:0]     point_z;
        logic [SEG_W-1:0]       segment;
        logic [FRAC_IN_W-1:0]   fraction;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        status_t            status;
    } out_item_t;

    typedef struct packed {
        logic       load_item;
        logic       chk;
        logic       cu;
        logic       wgt;
        logic       rd_en;
        logic [1:0] rd_idx;
        logic       mul_en;
        logic [1:0] mul_idx;
        logic       acc_en;
        logic       rnd;
        logic       div_step;
        logic       load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic run;
        logic is_pos;
    } dp_stat_t;

endpackage

// ----- hdl/cubic_bspline_evaluator.sv -----
// ----------------------------------------------------------------------------
// cubic_bspline_evaluator - uniform cubic B-spline position/tangent engine
// Appends 3D control points and evaluates the curve or its derivative.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    in_item_t  (func, point, seg, frac)
//   m_        out        m_valid/m_ready    out_item_t (out_x/y/z, status)
//
// Append, range error, unused code: check then completion; no new item until done.
// Tangent adds parameter, weight, multiply-accumulate and rounding states; position
// also runs the divide-by-three steps. Per evaluation the store is read four times.
// Synchronous active-low reset clears control and point count only.
// A stalled result holds the next finished item in its last state, input blocked.
// ----------------------------------------------------------------------------
module cubic_bspline_evaluator
    import cbspl_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    cbspl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    cbspl_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_data  (m_data)
    );

endmodule

// ----- hdl/cbspl_ctrl.sv -----
// ----------------------------------------------------------------------------
// cbspl_ctrl - sequencing controller
// One-hot state machine issuing datapath commands and owning both handshakes.
// ----------------------------------------------------------------------------
module cbspl_ctrl
    import cbspl_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_CHK  = 8'b0000_0010,
        S_CU   = 8'b0000_0100,
        S_WGT  = 8'b0000_1000,
        S_MAC  = 8'b0001_0000,
        S_RND  = 8'b0010_0000,
        S_DIV  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    localparam logic [STEP_W-1:0] MAC_LAST = STEP_W'(NUM_TAPS + 1);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic                m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_CHK;
                end
            end
            S_CHK: begin
                cmd.chk    = 1'b1;
                state_next = stat.run ? S_CU : S_DONE;
            end
            S_CU: begin
                cmd.cu     = 1'b1;
                state_next = S_WGT;
            end
            S_WGT: begin
                cmd.wgt    = 1'b1;
                cnt_next   = '0;
                state_next = S_MAC;
            end
            S_MAC: begin
                cmd.rd_en   = (cnt_reg < STEP_W'(NUM_TAPS));
                cmd.rd_idx  = cnt_reg[1:0];
                cmd.mul_en  = (cnt_reg >= STEP_W'(1)) && (cnt_reg <= STEP_W'(NUM_TAPS));
                cmd.mul_idx = 2'(cnt_reg - STEP_W'(1));
                cmd.acc_en  = (cnt_reg >= STEP_W'(2));
                if (cnt_reg == MAC_LAST) begin
                    cnt_next   = '0;
                    state_next = S_RND;
                end else begin
                    cnt_next = cnt_reg + STEP_W'(1);
                end
            end
            S_RND: begin
                cmd.rnd    = 1'b1;
                cnt_next   = '0;
                state_next = stat.is_pos ? S_DIV : S_DONE;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    cnt_next   = '0;
                    state_next = S_DONE;
                end else begin
                    cnt_next = cnt_reg + STEP_W'(1);
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && m_valid_reg && !m_ready) |=> (state_reg == S_DONE))
        else $error("result dropped while output register busy");

    a_mac_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MAC) |-> (cnt_reg <= MAC_LAST))
        else $error("MAC step counter out of range");

    a_valid_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside completion state");
`endif

endmodule

// ----- hdl/cbspl_datapath.sv -----
// ----------------------------------------------------------------------------
// cbspl_datapath - point store, weight generation, MAC lanes and divider
// Three multiplier lanes (x, y, z), rounding, saturation, divide by three.
// ----------------------------------------------------------------------------
module cbspl_datapath
    import cbspl_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  in_item_t  s_data,
    input  dp_cmd_t   cmd,
    output dp_stat_t  stat,
    output out_item_t m_data
);

    localparam int TW2 = 2 * FRAC_BITS;
    localparam int WS  = WGT_W + 2;
    localparam int FR_UP = (FRAC_BITS >= FRAC_IN_W) ? FRAC_BITS - FRAC_IN_W : 0;
    localparam int FR_DN = (FRAC_BITS <  FRAC_IN_W) ? FRAC_IN_W - FRAC_BITS : 0;

    localparam logic [TW2-1:0]          HALF_T   = TW2'(2 ** (FRAC_BITS - 1));
    localparam logic signed [WS-1:0]    ONE_W    = WS'(2 ** FRAC_BITS);
    localparam logic signed [SUM_W-1:0] HALF_POS = SUM_W'(3 * (2 ** FRAC_BITS));
    localparam logic signed [SUM_W-1:0] HALF_TAN = SUM_W'(2 ** FRAC_BITS);
    localparam logic signed [S1_W-1:0]  LIM3     = S1_W'(64'sd6442450944);
    localparam logic signed [S1_W-1:0]  LIM3_NEG = S1_W'(-64'sd6442450944);
    localparam logic signed [S1_W-1:0]  C_MAX    = S1_W'(64'sd2147483647);
    localparam logic signed [S1_W-1:0]  C_MIN    = S1_W'(-64'sd2147483648);
    localparam coord_t                  SAT_MAX  = 32'sh7FFF_FFFF;
    localparam coord_t                  SAT_MIN  = 32'sh8000_0000;

    function automatic logic [FRAC_BITS-1:0] round_frac(input logic [TW2-1:0] p);
        logic [TW2-1:0] s;
        s = p + HALF_T;
        return s[TW2-1:FRAC_BITS];
    endfunction

    in_item_t                      item_reg;
    logic [CNT_W-1:0]              count_reg;
    logic [NUM_AXES*COORD_W-1:0]   mem [MAX_POINTS];
    logic [NUM_AXES*COORD_W-1:0]   rd_word_reg;
    status_t                       status_reg;
    logic                          run_reg;

    logic [FRAC_BITS-1:0]          t, t2_reg, t2_rnd, t3_rnd;
    logic signed [WGT_W-1:0]       w_reg [NUM_TAPS];
    logic signed [WGT_W-1:0]       w_next [NUM_TAPS];
    logic signed [PROD_W-1:0]      prod_reg [NUM_AXES];
    logic signed [SUM_W-1:0]       acc_reg [NUM_AXES];
    coord_t                        mul_a [NUM_AXES];
    logic signed [WGT_W-1:0]       mul_b;

    coord_t                        res_reg [NUM_AXES];
    logic                          sat_hi_reg [NUM_AXES];
    logic                          sat_lo_reg [NUM_AXES];
    logic [DIV_W-1:0]              dv_reg [NUM_AXES];
    logic [DIV_W-1:0]              dv_next [NUM_AXES];
    logic [1:0]                    rem_reg [NUM_AXES];
    logic [1:0]                    rem_next [NUM_AXES];
    logic [DIV_W-1:0]              q_reg [NUM_AXES];
    logic [DIV_W-1:0]              q_next [NUM_AXES];
    out_item_t                     out_reg;

    logic                          is_pos, is_eval, full, seg_err, run, wr_en;
    logic [IDX_W-1:0]              rd_addr_full;
    logic [ADDR_W-1:0]             rd_addr;

    // control decode
    always_comb begin
        is_pos  = (item_reg.func == FUNC_POS);
        is_eval = (item_reg.func == FUNC_POS) || (item_reg.func == FUNC_TAN);
        full    = (count_reg == CNT_W'(MAX_POINTS));
        seg_err = is_eval &&
                  ((IDX_W'(item_reg.segment) + IDX_W'(NUM_TAPS - 1)) >= IDX_W'(count_reg));
        run     = is_eval && !seg_err;
        wr_en   = cmd.chk && (item_reg.func == FUNC_APPEND) && !full;
        rd_addr_full = IDX_W'(item_reg.segment) + IDX_W'(cmd.rd_idx);
        rd_addr      = rd_addr_full[ADDR_W-1:0];
    end

    assign stat.run    = run;
    assign stat.is_pos = is_pos;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (wr_en) begin
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[ADDR_W-1:0]] <= {item_reg.point_z, item_reg.point_y, item_reg.point_x};
        end
        if (cmd.rd_en) begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_data;
        end
        if (cmd.chk) begin
            run_reg <= run;
            if (item_reg.func == FUNC_APPEND && full) begin
                status_reg <= STATUS_FULL;
            end else if (seg_err) begin
                status_reg <= STATUS_SEG_ERR;
            end else begin
                status_reg <= STATUS_OK;
            end
        end
    end

    // fraction to weight precision, powers of t
    always_comb begin
        if (FRAC_BITS >= FRAC_IN_W) begin
            t = FRAC_BITS'(FRAC_BITS'(item_reg.fraction) << FR_UP);
        end else begin
            t = FRAC_BITS'(item_reg.fraction >> FR_DN);
        end
        t2_rnd = round_frac(prod_reg[0][TW2-1:0]);
        t3_rnd = round_frac(prod_reg[0][TW2-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (cmd.cu) begin
            t2_reg <= t2_rnd;
        end
    end

    // basis weight numerators
    always_comb begin
        logic signed [WS-1:0] tw, t2w, t3w, tw2, t2w3, t3w3;
        tw   = WS'(t);
        t2w  = WS'(t2_reg);
        t3w  = WS'(t3_rnd);
        tw2  = tw <<< 1;
        t2w3 = t2w + (t2w <<< 1);
        t3w3 = t3w + (t3w <<< 1);
        if (is_pos) begin
            w_next[0] = WGT_W'(ONE_W - t3w + t2w3 - (tw + tw2));
            w_next[1] = WGT_W'(t3w3 - (t2w3 <<< 1) + (ONE_W <<< 2));
            w_next[2] = WGT_W'(ONE_W - t3w3 + t2w3 + (tw + tw2));
            w_next[3] = WGT_W'(t3w);
        end else begin
            w_next[0] = WGT_W'(tw2 - t2w - ONE_W);
            w_next[1] = WGT_W'(t2w3 - (tw <<< 2));
            w_next[2] = WGT_W'(ONE_W + tw2 - t2w3);
            w_next[3] = WGT_W'(t2w);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wgt) begin
            for (int i = 0; i < NUM_TAPS; i++) begin
                w_reg[i] <= w_next[i];
            end
        end
    end

    // multiplier lanes, lane 0 also forms t^2 and t^3
    always_comb begin
        mul_b = cmd.mul_en ? w_reg[cmd.mul_idx] : WGT_W'(t);
        for (int l = 0; l < NUM_AXES; l++) begin
            mul_a[l] = coord_t'(rd_word_reg[l*COORD_W +: COORD_W]);
        end
        if (!cmd.mul_en) begin
            mul_a[0] = cmd.cu ? COORD_W'(t2_rnd) : COORD_W'(t);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.chk || cmd.cu || cmd.mul_en) begin
            for (int l = 0; l < NUM_AXES; l++) begin
                prod_reg[l] <= PROD_W'(mul_a[l]) * PROD_W'(mul_b);
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int l = 0; l < NUM_AXES; l++) begin
            if (cmd.wgt) begin
                acc_reg[l] <= '0;
            end else if (cmd.acc_en) begin
                acc_reg[l] <= acc_reg[l] + SUM_W'(prod_reg[l]);
            end
        end
    end

    // divide by three, DIV_STEP_BITS quotient bits per step
    always_comb begin
        logic [DIV_W-1:0] d, q;
        logic [1:0]       r;
        logic [2:0]       rr;
        logic             qb;
        for (int l = 0; l < NUM_AXES; l++) begin
            d = dv_reg[l];
            q = q_reg[l];
            r = rem_reg[l];
            for (int k = 0; k < DIV_STEP_BITS; k++) begin
                rr = {r, d[DIV_W-1]};
                qb = (rr >= 3'd3);
                r  = qb ? 2'(rr - 3'd3) : rr[1:0];
                q  = {q[DIV_W-2:0], qb};
                d  = {d[DIV_W-2:0], 1'b0};
            end
            dv_next[l]  = d;
            q_next[l]   = q;
            rem_next[l] = r;
        end
    end

    always_ff @(posedge aclk) begin
        logic signed [SUM_W-1:0] rs;
        logic signed [S1_W-1:0]  s1;
        logic signed [S1_W-1:0]  u;
        for (int l = 0; l < NUM_AXES; l++) begin
            rs = acc_reg[l] + (is_pos ? HALF_POS : HALF_TAN);
            s1 = rs[SUM_W-1:FRAC_BITS+1];
            u  = s1 + LIM3;
            if (cmd.rnd) begin
                if (s1 > C_MAX) begin
                    res_reg[l] <= SAT_MAX;
                end else if (s1 < C_MIN) begin
                    res_reg[l] <= SAT_MIN;
                end else begin
                    res_reg[l] <= coord_t'(s1[COORD_W-1:0]);
                end
                sat_hi_reg[l] <= (s1 >= LIM3);
                sat_lo_reg[l] <= (s1 < LIM3_NEG);
                dv_reg[l]     <= DIV_W'(u[U_W-1:0]);
                q_reg[l]      <= '0;
                rem_reg[l]    <= '0;
            end else if (cmd.div_step) begin
                dv_reg[l]  <= dv_next[l];
                q_reg[l]   <= q_next[l];
                rem_reg[l] <= rem_next[l];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        coord_t v [NUM_AXES];
        for (int l = 0; l < NUM_AXES; l++) begin
            if (!run_reg) begin
                v[l] = '0;
            end else if (!is_pos) begin
                v[l] = res_reg[l];
            end else if (sat_hi_reg[l]) begin
                v[l] = SAT_MAX;
            end else if (sat_lo_reg[l]) begin
                v[l] = SAT_MIN;
            end else begin
                v[l] = coord_t'(q_reg[l][COORD_W-1:0] ^ {1'b1, {(COORD_W-1){1'b0}}});
            end
        end
        if (cmd.load_out) begin
            out_reg.out_x  <= v[0];
            out_reg.out_y  <= v[1];
            out_reg.out_z  <= v[2];
            out_reg.status <= status_reg;
        end
    end

    assign m_data = out_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond store depth");

    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |-> (rd_addr_full < IDX_W'(count_reg)))
        else $error("store read beyond written points");
`endif

endmodule
